// ----- sv/bfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared constants, codes, types and index helpers for the buddy free map.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

    // geometry of the managed memory
    localparam int MAX_ORDER = 10;
    localparam int ORD_W     = 4;
    localparam int LOC_W     = 10;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;

    // the map is stored as buddy pairs: one row holds both buddies of a level
    localparam int ROWS  = 2 ** MAX_ORDER;
    localparam int ROW_W = MAX_ORDER;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP = 2'd2;

    // one result word
    typedef struct packed {
        logic              is_free;
        logic [LOC_W-1:0]  rloc;
        logic [ORD_W-1:0]  rord;
        logic [STAT_W-1:0] status;
    } result_t;

    // one access to the free map ram
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [1:0]       wdata;
        logic             re;
        logic [ROW_W-1:0] raddr;
    } mem_req_t;

    // row of the buddy pair that holds block (k, loc)
    function automatic logic [ROW_W-1:0] row_of(input logic [ORD_W-1:0] k,
                                                 input logic [LOC_W-1:0] loc);
        logic [ROW_W:0]   base;
        logic [LOC_W-1:0] off;
        base = (ROW_W+1)'(ROWS) - ((ROW_W+1)'(ROWS) >> k);
        off  = loc >> k;
        return ROW_W'(base + (ROW_W+1)'(off >> 1));
    endfunction

    // which half of the pair row is block (k, loc) itself
    function automatic logic side_of(input logic [ORD_W-1:0] k,
                                     input logic [LOC_W-1:0] loc);
        logic [LOC_W-1:0] off;
        off = loc >> k;
        return off[0];
    endfunction

    // misaligned or out of range
    function automatic logic is_bad(input logic [ORD_W-1:0] k,
                                    input logic [LOC_W-1:0] loc);
        logic [LOC_W:0] mask;
        mask = ((LOC_W+1)'(1) << k) - (LOC_W+1)'(1);
        return (k > ORD_W'(MAX_ORDER)) || ((loc >> MAX_ORDER) != '0) ||
               ((mask & {1'b0, loc}) != '0);
    endfunction

endpackage

`default_nettype wire

// ----- sv/bfc_map_ram.sv -----
// ----------------------------------------------------------------------------
// bfc_map_ram
// Simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_map_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 2
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer: clears the map after reset, then checks each word and walks the
// free map one order per cycle with read-modify-write on buddy pair rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bfc_pkg::KIND_W-1:0]   in_kind,
    input  wire logic [bfc_pkg::ORD_W-1:0]    in_order,
    input  wire logic [bfc_pkg::LOC_W-1:0]    in_location,
    input  wire logic [bfc_pkg::ORD_W-1:0]    top_level,
    input  wire logic                         out_free,
    output logic                              res_valid,
    output bfc_pkg::result_t                  res,
    output bfc_pkg::mem_req_t                 mem_req,
    input  wire logic [1:0]                   rd_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_LOOK  = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [bfc_pkg::ROW_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [bfc_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [bfc_pkg::ORD_W-1:0]      ord_reg, ord_next;
    logic [bfc_pkg::LOC_W-1:0]      loc_reg, loc_next;
    logic                           first_reg, first_next;

    logic [bfc_pkg::ORD_W-1:0]      top_eff;
    logic                           bad;
    logic                           side;
    logic                           own_bit;
    logic                           bud_bit;
    logic [bfc_pkg::ORD_W-1:0]      ord_up;
    logic [bfc_pkg::LOC_W-1:0]      loc_up;

    // effective coalescing limit
    assign top_eff = (top_level > bfc_pkg::ORD_W'(bfc_pkg::MAX_ORDER)) ?
                     bfc_pkg::ORD_W'(bfc_pkg::MAX_ORDER) : top_level;

    assign bad     = bfc_pkg::is_bad(ord_reg, loc_reg);
    assign side    = bfc_pkg::side_of(ord_reg, loc_reg);
    assign own_bit = rd_data[side];
    assign bud_bit = rd_data[~side];
    assign ord_up  = ord_reg + bfc_pkg::ORD_W'(1);
    assign loc_up  = loc_reg & ~(bfc_pkg::LOC_W'(1) << ord_reg);

    assign in_ready = (state_reg == ST_IDLE);

    // next state and map access
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        ord_next     = ord_reg;
        loc_next     = loc_reg;
        first_next   = first_reg;
        mem_req      = '0;
        res_valid    = 1'b0;
        res          = '0;
        res.rord     = ord_reg;
        res.rloc     = loc_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = 2'b00;
                clr_cnt_next  = clr_cnt_reg + bfc_pkg::ROW_W'(1);
                if (clr_cnt_reg == bfc_pkg::ROW_W'(bfc_pkg::ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    kind_next  = in_kind;
                    ord_next   = in_order;
                    loc_next   = in_location;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (kind_reg == bfc_pkg::KIND_NOP || bad) begin
                    // answered without touching the map
                    if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = (kind_reg == bfc_pkg::KIND_NOP) ?
                                     bfc_pkg::STAT_OK : bfc_pkg::STAT_BAD;
                        state_next = ST_IDLE;
                    end
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = bfc_pkg::row_of(ord_reg, loc_reg);
                    first_next    = 1'b1;
                    state_next    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                priority if (kind_reg == bfc_pkg::KIND_PROBE) begin
                    if (out_free) begin
                        res_valid   = 1'b1;
                        res.status  = bfc_pkg::STAT_OK;
                        res.is_free = own_bit;
                        state_next  = ST_IDLE;
                    end
                end else if (first_reg && own_bit) begin
                    if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = bfc_pkg::STAT_DUP;
                        state_next = ST_IDLE;
                    end
                end else if (kind_reg == bfc_pkg::KIND_RELEASE && ord_reg < top_eff &&
                             bud_bit) begin
                    // merge: clear both buddies, climb and fetch the parent pair
                    mem_req.we    = 1'b1;
                    mem_req.waddr = bfc_pkg::row_of(ord_reg, loc_reg);
                    mem_req.wdata = 2'b00;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = bfc_pkg::row_of(ord_up, loc_up);
                    ord_next      = ord_up;
                    loc_next      = loc_up;
                    first_next    = 1'b0;
                end else begin
                    // mark this block free and finish
                    if (out_free) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = bfc_pkg::row_of(ord_reg, loc_reg);
                        mem_req.wdata = rd_data | (2'b01 << side);
                        res_valid     = 1'b1;
                        res.status    = bfc_pkg::STAT_OK;
                        state_next    = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // working item
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        ord_reg   <= ord_next;
        loc_reg   <= loc_next;
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// ----- sv/buddy_free_coalescer_top.sv -----
// ----------------------------------------------------------------------------
// buddy_free_coalescer_top
// Buddy system free map with coalescing on release.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  s_      | in  | kind, order, location (16 bits)
//  m_      | out | status, result_order, result_location, is_free (24 bits)
//  cfg_    | in  | top_level, write only
//
//  an item holds the block through accept, check and map read on load, probe or
//  release, and through accept and check only on a bad or unused-kind word;
//  a release adds one merge step for each order merged, and each such step is
//  one read-modify-write of a buddy pair row in the ram
//  after reset the map ram is cleared row by row, all 1024 rows, s_tready low
//  a result waits in the output register; a finished item stalls until it is
//  taken, and the next word is accepted while the result still waits
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_free_coalescer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // kind[1:0], order[5:2], location[15:6]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,     // status[1:0], result_order[5:2],
                                          // result_location[15:6], is_free[16]
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data  // top_level
);

    logic [bfc_pkg::ORD_W-1:0] top_level_reg;
    logic                      m_valid_reg;
    bfc_pkg::result_t          m_data_reg;
    logic                      out_free;
    logic                      res_valid;
    bfc_pkg::result_t          res;
    bfc_pkg::mem_req_t         mem_req;
    logic [1:0]                rd_data;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_level_reg <= bfc_pkg::ORD_W'(bfc_pkg::MAX_ORDER);
        end else if (cfg_wr_en) begin
            top_level_reg <= cfg_wr_data;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    bfc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tdata[1:0]),
        .in_order    (s_tdata[5:2]),
        .in_location (s_tdata[15:6]),
        .top_level   (top_level_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    bfc_map_ram #(
        .DEPTH  (bfc_pkg::ROWS),
        .ADDR_W (bfc_pkg::ROW_W),
        .DATA_W (2)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    // an answer with is_free set always carries the ok status
    a_free_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[1:0] == bfc_pkg::STAT_OK))
        else $error("is_free set with non-ok status");

    // no word is taken as the map clear begins, when reset is first released
    a_clear_busy: assert property (@(posedge aclk)
        ($past(!aresetn) && aresetn) |-> !s_tready)
        else $error("input accepted during map clear");

    // one item at a time: accept drops ready on the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // the order of a new ok answer with is_free clear never exceeds 15
    a_order_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == bfc_pkg::STAT_OK && !m_tdata[16] &&
         $rose(m_tvalid)) |-> (m_tdata[5:2] <= bfc_pkg::ORD_W'(15)))
        else $error("result order out of range");

endmodule

`default_nettype wire
